// ===== hdl/hse_pkg.sv =====
// Shared types and constants for the 2-D heat stencil unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package hse_pkg;
    localparam int MAX_CELLS_DEF   = 4096;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS       = 24;
    localparam int COEF_W          = 32;
    localparam int DIM_W           = 6;
    localparam int STEP_W          = 16;
    localparam int ADDR_IN_W       = 12;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CC    = 3'd5;

    // Datapath operation selected by the controller for the current cycle.
    typedef enum logic [2:0] {
        DP_NONE   = 3'd0,
        DP_WRITE  = 3'd1,  // store the cell value in both banks
        DP_INIT   = 3'd2,  // store 1.0 or 0.0 in both banks
        DP_RDREQ  = 3'd3,  // read the current bank at the address
        DP_TAP    = 3'd4,  // read one stencil tap from the source bank
        DP_STORE  = 3'd5   // write the stencil result to the other bank
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        logic [2:0]  tap;      // stencil tap 0..4: centre, left, right, up, down
        logic        clr_acc;
        logic        inner;    // init value for the current cell
        logic        swap;     // toggle the current bank
        logic        clr_sat;
    } t_dp_cmd;
endpackage
`default_nettype wire

// ===== hdl/hse_datapath.sv =====
// Grid banks, stencil multiply-accumulate and saturation for the heat stencil.
// Depends on hse_pkg; driven by hse_ctrl through a t_dp_cmd.
`default_nettype none
module hse_datapath
    import hse_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int AW = $clog2(MAX_CELLS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic signed [VALUE_WIDTH-1:0] i_wdata,
    input  wire logic signed [COEF_W-1:0]      i_coef_x,
    input  wire logic signed [COEF_W-1:0]      i_coef_y,
    input  wire logic signed [COEF_W-1:0]      i_coef_c,
    output logic signed [VALUE_WIDTH-1:0]      o_rdata,
    output logic                               o_sat
);
    localparam int PW  = COEF_W + VALUE_WIDTH;
    localparam int ACW = PW + 3;
    localparam logic signed [ACW-1:0] VMAX =
        $signed({{(ACW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [ACW-1:0] VMIN =
        $signed({{(ACW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});

    logic signed [VALUE_WIDTH-1:0] r_bank_a [MAX_CELLS];
    logic signed [VALUE_WIDTH-1:0] r_bank_b [MAX_CELLS];
    logic signed [VALUE_WIDTH-1:0] r_rd_a, r_rd_b;
    logic r_cur, r_rd_sel, r_sat;
    logic r_tap_v, r_mul_v;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [PW-1:0] r_prod;
    logic signed [ACW-1:0] r_acc;

    logic signed [VALUE_WIDTH-1:0] rd_val, init_val, res;
    logic signed [ACW-1:0] rounded;
    logic sat_hi, sat_lo;
    logic wr_a, wr_b;
    logic signed [VALUE_WIDTH-1:0] wr_val;

    assign rd_val   = r_rd_sel ? r_rd_b : r_rd_a;
    assign init_val = i_cmd.inner ? VALUE_WIDTH'(64'sd1 <<< FRAC_BITS)
                                  : '0;

    // Bank writes: write and init store both, stencil store targets the other bank.
    always_comb begin
        wr_a   = 1'b0;
        wr_b   = 1'b0;
        wr_val = i_wdata;
        unique case (i_cmd.op)
            DP_WRITE: begin wr_a = 1'b1; wr_b = 1'b1; end
            DP_INIT: begin wr_a = 1'b1; wr_b = 1'b1; wr_val = init_val; end
            DP_STORE: begin
                wr_a = r_cur; wr_b = !r_cur; wr_val = res;
            end
            default: ;
        endcase
    end

    // The read registers keep their value until the next read request or tap.
    always_ff @(posedge i_clk) begin
        if (wr_a) r_bank_a[i_addr] <= wr_val;
        if (wr_b) r_bank_b[i_addr] <= wr_val;
        if (i_cmd.op == DP_RDREQ || i_cmd.op == DP_TAP) begin
            r_rd_a <= r_bank_a[i_addr];
            r_rd_b <= r_bank_b[i_addr];
        end
    end

    // Round the Q19.48 sum to Q8.24 and saturate.
    always_comb begin
        rounded = (r_acc + (ACW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sat_hi  = rounded > VMAX;
        sat_lo  = rounded < VMIN;
        if (sat_hi)      res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        else if (sat_lo) res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        else             res = rounded[VALUE_WIDTH-1:0];
    end

    // Tap read -> multiply -> accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= 1'b0;
            r_sat    <= 1'b0;
            r_tap_v  <= 1'b0;
            r_mul_v  <= 1'b0;
            r_rd_sel <= 1'b0;
        end else begin
            if (i_cmd.op == DP_RDREQ || i_cmd.op == DP_TAP) r_rd_sel <= r_cur;
            r_tap_v <= (i_cmd.op == DP_TAP);
            r_mul_v <= r_tap_v;
            if (i_cmd.swap) r_cur <= !r_cur;
            if (i_cmd.clr_sat) r_sat <= 1'b0;
            else if (i_cmd.op == DP_STORE && (sat_hi || sat_lo)) r_sat <= 1'b1;
        end
        unique case (i_cmd.tap)
            3'd0: r_coef <= i_coef_c;
            3'd1, 3'd2: r_coef <= i_coef_x;
            default: r_coef <= i_coef_y;
        endcase
        r_prod <= r_coef * rd_val;
        if (i_cmd.clr_acc) r_acc <= '0;
        else if (r_mul_v) r_acc <= r_acc + ACW'(r_prod);
    end

    // r_coef lines up with rd_val: both register the cycle after the tap read.
    assign o_rdata = rd_val;
    assign o_sat   = r_sat;
endmodule
`default_nettype wire

// ===== hdl/hse_ctrl.sv =====
// Sequencer for the heat stencil: walks init, run and single-cell operations.
// Depends on hse_pkg; commands hse_datapath.
`default_nettype none
module hse_ctrl
    import hse_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    localparam int AW = $clog2(MAX_CELLS)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_op                i_op,
    input  wire logic [ADDR_IN_W-1:0] i_addr,
    input  wire logic [DIM_W-1:0]   i_cols,
    input  wire logic [DIM_W-1:0]   i_rows,
    input  wire logic [STEP_W-1:0]  i_steps,
    input  wire logic               i_out_ready,
    output logic                    o_busy,
    output logic                    o_out_valid,
    output logic                    o_err,
    output logic                    o_is_read,
    output logic                    o_is_run,
    output t_dp_cmd                 o_cmd,
    output logic [AW-1:0]           o_addr
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RDWAIT, S_RDLAT, S_TAP, S_DRAIN, S_STORE, S_NEXT, S_RESULT
    } t_state;

    localparam int CW = (AW + 1 > 2 * (DIM_W + 1)) ? AW + 1 : 2 * (DIM_W + 1);

    t_state r_state;
    logic [DIM_W-1:0] r_i, r_j;
    logic [CW-1:0] r_base;      // j*(cols+1)
    logic [STEP_W-1:0] r_step;
    logic [2:0] r_tap, r_drain;
    logic r_err, r_read, r_run;
    logic [CW-1:0] total, w, idx, tap_idx, cur_idx, in_addr;
    logic bad, inner;

    assign w       = CW'(i_cols) + CW'(1);
    assign total   = w * (CW'(i_rows) + CW'(1));
    assign in_addr = CW'(i_addr);
    assign bad     = (in_addr >= total) || (in_addr >= CW'(MAX_CELLS));
    assign cur_idx = r_base + CW'(r_i);
    assign inner   = r_i >= 1 && r_i < i_cols && r_j >= 1 && r_j < i_rows;

    always_comb begin
        unique case (r_tap)
            3'd0: tap_idx = cur_idx;
            3'd1: tap_idx = cur_idx - CW'(1);
            3'd2: tap_idx = cur_idx + CW'(1);
            3'd3: tap_idx = cur_idx - w;
            default: tap_idx = cur_idx + w;
        endcase
    end

    always_comb begin
        o_cmd = '{op: DP_NONE, tap: r_tap, clr_acc: 1'b0, inner: inner,
                  swap: 1'b0, clr_sat: 1'b0};
        idx = cur_idx;
        unique case (r_state)
            S_IDLE: begin
                idx = in_addr;
                o_cmd.clr_sat = i_start;
                if (i_start && !bad && i_op == OP_WRITE) o_cmd.op = DP_WRITE;
                if (i_start && i_op == OP_READ) o_cmd.op = DP_RDREQ;
            end
            S_INIT:  if (cur_idx < CW'(MAX_CELLS)) o_cmd.op = DP_INIT;
            S_TAP: begin idx = tap_idx; o_cmd.op = DP_TAP; end
            S_STORE: o_cmd.op = DP_STORE;
            S_NEXT:  begin
                o_cmd.clr_acc = 1'b1;
                o_cmd.swap = (r_i == 0 && r_j == 0);
            end
            default: ;
        endcase
        o_addr = idx[AW-1:0];
    end

    // Controller state and registered result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err <= 1'b0; r_read <= 1'b0; r_run <= 1'b0;
            r_i <= '0; r_j <= '0; r_base <= '0; r_step <= '0;
            r_tap <= '0; r_drain <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_err  <= bad && (i_op == OP_WRITE || i_op == OP_READ);
                    r_read <= (i_op == OP_READ) && !bad;
                    r_run  <= (i_op == OP_RUN);
                    r_i <= '0; r_j <= '0; r_base <= '0;
                    r_step <= i_steps; r_tap <= '0;
                    unique case (i_op)
                        OP_INIT: r_state <= S_INIT;
                        OP_READ: r_state <= S_RDWAIT;
                        OP_RUN: begin
                            r_i <= DIM_W'(1); r_j <= DIM_W'(1); r_base <= w;
                            r_state <= (i_steps == '0) ? S_RESULT : S_NEXT;
                            r_step <= i_steps;
                        end
                        default: r_state <= S_RESULT;
                    endcase
                end
                S_INIT: begin
                    if (r_i == i_cols) begin
                        r_i <= '0;
                        r_base <= r_base + w;
                        r_j <= r_j + DIM_W'(1);
                        if (r_j == i_rows) r_state <= S_RESULT;
                    end else r_i <= r_i + DIM_W'(1);
                end
                S_RDWAIT: r_state <= S_RDLAT;
                S_RDLAT:  r_state <= S_RESULT;
                S_NEXT: begin
                    // Pick the next interior cell, or finish the step.
                    if (r_i == 0 && r_j == 0) begin
                        r_step <= r_step - STEP_W'(1);
                        r_i <= DIM_W'(1); r_j <= DIM_W'(1); r_base <= w;
                        if (r_step == STEP_W'(1)) r_state <= S_RESULT;
                    end else if (r_j >= i_rows || r_i >= i_cols) begin
                        r_i <= '0; r_j <= '0; r_base <= '0;
                    end else if (cur_idx + w >= CW'(MAX_CELLS)) begin
                        if (r_i + DIM_W'(1) >= i_cols) begin
                            r_i <= DIM_W'(1); r_j <= r_j + DIM_W'(1);
                            r_base <= r_base + w;
                        end else r_i <= r_i + DIM_W'(1);
                    end else begin
                        r_tap <= '0; r_state <= S_TAP;
                    end
                end
                S_TAP: begin
                    r_tap <= r_tap + 3'd1;
                    if (r_tap == 3'd4) begin r_drain <= '0; r_state <= S_DRAIN; end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 3'd1;
                    if (r_drain == 3'd2) r_state <= S_STORE;
                end
                S_STORE: begin
                    r_state <= S_NEXT;
                    if (r_i + DIM_W'(1) >= i_cols) begin
                        r_i <= DIM_W'(1); r_j <= r_j + DIM_W'(1);
                        r_base <= r_base + w;
                    end else r_i <= r_i + DIM_W'(1);
                end
                S_RESULT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESULT);
    assign o_err       = r_err;
    assign o_is_read   = r_read;
    assign o_is_run    = r_run;
endmodule
`default_nettype wire

// ===== hdl/heat_stencil_euler_2d_unit.sv =====
// Explicit Euler five-point heat stencil on a ping-pong grid of Q8.24 cells.
// A run fetches the five stencil taps of each updated interior cell in turn
// through the single bank read port. One item at a time; synchronous
// active-low reset sets control and configuration registers, grid banks are
// undefined until written. Depends on hse_pkg, hse_ctrl, hse_datapath.
`default_nettype none
module heat_stencil_euler_2d_unit
    import hse_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // operation[1:0], cell_address[13:2], cell_value[VALUE_WIDTH+13:14], zero pad
    input  wire logic [((VALUE_WIDTH+14+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // read_value[VALUE_WIDTH-1:0], address_error, saturated, zero pad
    output logic [((VALUE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COEF_W-1:0]    i_cfg_data
);
    localparam int AW  = $clog2(MAX_CELLS);
    localparam int OTW = ((VALUE_WIDTH + 2 + 7) / 8) * 8;

    logic [DIM_W-1:0] r_cols, r_rows;
    logic [STEP_W-1:0] r_steps;
    logic signed [COEF_W-1:0] r_cx, r_cy, r_cc;
    logic busy, err, is_read, is_run, dsat, start;
    logic signed [VALUE_WIDTH-1:0] rdata;
    t_dp_cmd cmd;
    logic [AW-1:0] addr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= DIM_W'(63); r_rows <= DIM_W'(63); r_steps <= STEP_W'(1);
            r_cx <= '0; r_cy <= '0; r_cc <= COEF_W'(32'sh0100_0000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COLS:  r_cols  <= i_cfg_data[DIM_W-1:0];
                REG_ROWS:  r_rows  <= i_cfg_data[DIM_W-1:0];
                REG_STEPS: r_steps <= i_cfg_data[STEP_W-1:0];
                REG_CX:    r_cx    <= i_cfg_data;
                REG_CY:    r_cy    <= i_cfg_data;
                REG_CC:    r_cc    <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && !busy;

    hse_ctrl #(.MAX_CELLS(MAX_CELLS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start),
        .i_op(t_op'(s_axis_tdata[1:0])), .i_addr(s_axis_tdata[13:2]),
        .i_cols(r_cols), .i_rows(r_rows), .i_steps(r_steps),
        .i_out_ready(m_axis_tready), .o_busy(busy), .o_out_valid(m_axis_tvalid),
        .o_err(err), .o_is_read(is_read), .o_is_run(is_run), .o_cmd(cmd), .o_addr(addr)
    );

    hse_datapath #(.MAX_CELLS(MAX_CELLS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_addr(addr),
        .i_wdata(s_axis_tdata[VALUE_WIDTH+13:14]),
        .i_coef_x(r_cx), .i_coef_y(r_cy), .i_coef_c(r_cc),
        .o_rdata(rdata), .o_sat(dsat)
    );

    // Read data stays in the bank output register until the result is taken.
    assign m_axis_tdata = OTW'({is_run && dsat, err,
                                is_read ? rdata : {VALUE_WIDTH{1'b0}}});
endmodule
`default_nettype wire

// ===== sim/heat_stencil_euler_2d_unit_tb.sv =====
// Self-checking testbench for the 2-D explicit Euler heat stencil unit.
// Directed and random items are checked against a built-in grid predictor.
// Depends on hse_pkg and heat_stencil_euler_2d_unit.
`default_nettype none
module heat_stencil_euler_2d_unit_tb;
    import hse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = MAX_CELLS_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
    localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;

    typedef struct {
        logic signed [31:0] read_value;
        logic               address_error;
        logic               saturated;
    } t_cell_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // operation, cell_address, cell_value, zero pad
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_value, address_error, saturated, zero pad
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;

    int mismatches = 0;
    int replies_seen = 0;
    int cycles = 0;
    int burst_left = 0;

    heat_stencil_euler_2d_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic void report(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        mismatches++;
    endfunction

    // Grid predictor and store of expected replies.
    class heat_grid_board;
        logic signed [31:0] bank[2][CELLS];
        bit                 cur;
        int                 cols = 63, rows = 63, steps = 1;
        logic signed [31:0] cx = 0, cy = 0, cc = ONE_Q8_24;
        t_cell_reply        pending_replies[$];

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_COLS:  cols = d[5:0];
                REG_ROWS:  rows = d[5:0];
                REG_STEPS: steps = d[15:0];
                REG_CX:    cx = d;
                REG_CY:    cy = d;
                REG_CC:    cc = d;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] stencil(int idx, int w, output bit clip);
            logic signed [71:0] acc;
            bit s;
            acc = 0;
            s = cur;
            acc = acc + longint'(cc) * longint'(bank[s][idx]);
            acc = acc + longint'(cx) * longint'(bank[s][idx-1]);
            acc = acc + longint'(cx) * longint'(bank[s][idx+1]);
            acc = acc + longint'(cy) * longint'(bank[s][idx-w]);
            acc = acc + longint'(cy) * longint'(bank[s][idx+w]);
            acc = (acc + 72'sd8388608) >>> 24;
            clip = 1'b0;
            if (acc > 72'sd2147483647) begin
                clip = 1'b1;
                return 32'h7fff_ffff;
            end
            if (acc < -72'sd2147483648) begin
                clip = 1'b1;
                return 32'h8000_0000;
            end
            return acc[31:0];
        endfunction

        function bit run_steps();
            int w;
            bit sat, clip;
            w = cols + 1;
            sat = 1'b0;
            for (int m = 0; m < steps; m++) begin
                for (int j = 1; j + 1 <= rows; j++) begin
                    for (int i = 1; i + 1 <= cols; i++) begin
                        if (i + j * w + w < CELLS) begin
                            bank[!cur][i + j * w] = stencil(i + j * w, w, clip);
                            sat |= clip;
                        end
                    end
                end
                cur = !cur;
            end
            return sat;
        endfunction

        function void note_item(t_op op, logic [11:0] addr, logic [31:0] v);
            t_cell_reply r;
            bit bad, inner;
            int idx;
            r = '{0, 1'b0, 1'b0};
            bad = addr >= (cols + 1) * (rows + 1);
            case (op)
                OP_INIT: begin
                    for (int j = 0; j <= rows; j++) begin
                        for (int i = 0; i <= cols; i++) begin
                            idx = i + j * (cols + 1);
                            inner = i >= 1 && i + 1 <= cols && j >= 1 && j + 1 <= rows;
                            if (idx < CELLS) begin
                                bank[0][idx] = inner ? ONE_Q8_24 : 0;
                                bank[1][idx] = inner ? ONE_Q8_24 : 0;
                            end
                        end
                    end
                end
                OP_WRITE: begin
                    if (bad) begin
                        r.address_error = 1'b1;
                    end else begin
                        bank[0][addr] = v;
                        bank[1][addr] = v;
                    end
                end
                OP_RUN: r.saturated = run_steps();
                default: begin
                    if (bad) r.address_error = 1'b1;
                    else r.read_value = bank[cur][addr];
                end
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [39:0] d);
            t_cell_reply e;
            if (pending_replies.size() == 0) begin
                report("unexpected reply", d, 0);
                return;
            end
            e = pending_replies.pop_front();
            if (d[31:0] !== e.read_value) report("read_value", d[31:0], e.read_value);
            if (d[32] !== e.address_error) report("address_error", d[32], e.address_error);
            if (d[33] !== e.saturated) report("saturated", d[33], e.saturated);
        endfunction
    endclass

    heat_grid_board board = new();

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Cycle limit guards against a hang.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: changing stall pattern, plus one long hold-off to back up the block.
    int stall_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata);
            replies_seen <= replies_seen + 1;
        end
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (!hold_done && replies_seen == 40) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one item; the sender may idle between bursts of random length.
    task automatic send_item(t_op op, logic [11:0] addr, logic [31:0] v);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v, addr, op};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(op, addr, v);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_reg(idx, d);
    endtask

    task automatic read_cell(logic [11:0] addr);
        send_item(OP_READ, addr, $urandom);
    endtask

    initial begin
        int total;
        logic [31:0] v;
        logic [11:0] a;
        int pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the whole store first, so no read ever meets an unwritten cell.
        send_item(OP_INIT, 12'd0, 32'd0);
        read_cell(12'd0);
        read_cell(12'd65);
        read_cell(12'd4095);
        send_item(OP_WRITE, 12'd0, 32'h7fff_ffff);
        send_item(OP_WRITE, 12'd4095, 32'h8000_0000);
        send_item(OP_WRITE, 12'd130, 32'hffff_ffff);
        read_cell(12'd0);
        read_cell(12'd4095);
        send_item(OP_RUN, 12'hfff, 32'hffff_ffff);
        read_cell(12'd130);

        // Small grid: bad addresses, zero steps, extreme weights.
        wait_idle();
        write_reg(REG_COLS, 32'd2);
        write_reg(REG_ROWS, 32'd2);
        write_reg(REG_STEPS, 32'd0);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_item(OP_WRITE, 12'd9, 32'h1234_5678);
        read_cell(12'd9);
        send_item(OP_RUN, 12'd0, 32'd0);
        read_cell(12'd4);
        wait_idle();
        write_reg(REG_STEPS, 32'd2);
        write_reg(REG_CX, 32'h7fff_ffff);
        write_reg(REG_CY, 32'h8000_0000);
        write_reg(REG_CC, 32'h8000_0000);
        send_item(OP_RUN, 12'd0, 32'd0);
        read_cell(12'd4);

        // No interior cell: a run only swaps the banks, here the longest run.
        wait_idle();
        write_reg(REG_COLS, 32'd1);
        write_reg(REG_ROWS, 32'd0);
        write_reg(REG_STEPS, 32'd65535);
        send_item(OP_RUN, 12'd0, 32'd0);
        read_cell(12'd1);
        wait_idle();
        write_reg(REG_STEPS, 32'd1);
        send_item(OP_RUN, 12'd0, 32'd0);
        read_cell(12'd0);

        // Random phases with mostly small grids and mostly stable weights.
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_COLS, $urandom_range(0, 1));
            end else begin
                write_reg(REG_COLS, $urandom_range(2, 9));
            end
            write_reg(REG_ROWS, (ph == 7) ? 63 : $urandom_range(2, 9));
            write_reg(REG_STEPS, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4));
            if (ph % 4 == 3) begin
                write_reg(REG_CX, $urandom);
                write_reg(REG_CY, $urandom);
                write_reg(REG_CC, $urandom);
            end else begin
                write_reg(REG_CX, $urandom_range(0, 32'h0040_0000));
                write_reg(REG_CY, $urandom_range(0, 32'h0040_0000));
                write_reg(REG_CC, $urandom_range(32'h0000_0000, ONE_Q8_24));
            end
            total = (board.cols + 1) * (board.rows + 1);
            if (ph == 7) write_reg(REG_STEPS, 1);
            for (int k = 0; k < 15; k++) begin
                a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, total - 1);
                v = $urandom;
                pick = $urandom_range(0, 19);
                if (pick < 2) send_item(OP_INIT, a, v);
                else if (pick < 9) send_item(OP_WRITE, a, v);
                else if (pick < 12 && ph != 7) send_item(OP_RUN, a, v);
                else send_item(OP_READ, a, v);
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && board.pending_replies.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== heat_stencil_euler_2d_unit.f =====
hdl/hse_pkg.sv
hdl/hse_datapath.sv
hdl/hse_ctrl.sv
hdl/heat_stencil_euler_2d_unit.sv
sim/heat_stencil_euler_2d_unit_tb.sv
